// ----- hw/rtl/lpf_pkg.sv -----
// lpf_pkg: shared constants, opcodes, state codes and request structs
// for the linked pool fifo; no dependencies
package lpf_pkg;

  // pool geometry; null is the index POOL_DEPTH
  localparam int POOL_DEPTH = 16;
  localparam int ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int IDX_W      = $clog2(POOL_DEPTH + 1);
  localparam logic [IDX_W-1:0] NIL_SLOT = IDX_W'(POOL_DEPTH);

  // payload widths
  localparam int ID_W    = 16;
  localparam int PRICE_W = 32;
  localparam int DATA_W  = ID_W + PRICE_W;
  localparam int OP_W    = 2;

  localparam logic [ID_W-1:0] EMPTY_ID = ID_W'(9999);

  // output tdata bit positions
  localparam int OUT_EMPTY_BIT = DATA_W;
  localparam int OUT_FULL_BIT  = DATA_W + 1;
  localparam int OUT_DONE_BIT  = DATA_W + 2;
  localparam int OUT_BITS      = DATA_W + 3;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  // opcodes
  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_QRY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LINK = 4'b0010,
    ST_DATA = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // link memory request
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [IDX_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } link_req_t;

  // data memory request
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } data_req_t;

  // one result item
  typedef struct packed {
    logic               op_done;
    logic               is_full;
    logic               is_empty;
    logic [PRICE_W-1:0] front_price;
    logic [ID_W-1:0]    front_id;
  } result_t;

endpackage

// ----- hw/rtl/lpf_ram.sv -----
// lpf_ram: generic single-write, single-read synchronous ram
// registered read; no dependencies
module lpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/lpf_ctrl.sv -----
// lpf_ctrl: sequencer for enqueue, dequeue and query on the slot pool
// depends on lpf_pkg; drives the link and data rams through request structs
module lpf_ctrl
  import lpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [ID_W-1:0]    in_id,
  input  logic [PRICE_W-1:0] in_price,
  output link_req_t          link_req,
  input  logic [IDX_W-1:0]   link_rd_data,
  output data_req_t          data_req,
  input  logic [DATA_W-1:0]  data_rd_data,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  state_t             state, state_next;
  logic [IDX_W-1:0]   head, head_next;
  logic [IDX_W-1:0]   tail, tail_next;
  logic [IDX_W-1:0]   free_head, free_head_next;
  // slots at or above fill were never handed out: their link is index + 1
  logic [IDX_W-1:0]   fill, fill_next;
  logic [OP_W-1:0]    op_q, op_q_next;
  logic               fresh_q, fresh_q_next;
  logic               done_q, done_q_next;
  logic [ID_W-1:0]    front_id, front_id_next;
  logic [PRICE_W-1:0] front_price, front_price_next;

  logic head_nil, free_nil;
  logic [IDX_W-1:0] free_link;

  assign head_nil  = (head >= NIL_SLOT);
  assign free_nil  = (free_head >= NIL_SLOT);
  assign in_ready  = (state == ST_IDLE);
  assign free_link = fresh_q ? (free_head + IDX_W'(1)) : link_rd_data;

  // sequencer
  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    free_head_next   = free_head;
    fill_next        = fill;
    op_q_next        = op_q;
    fresh_q_next     = fresh_q;
    done_q_next      = done_q;
    front_id_next    = front_id;
    front_price_next = front_price;
    link_req         = '0;
    data_req         = '0;
    res_valid        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_q_next   = in_op;
          done_q_next = 1'b0;
          state_next  = ST_DONE;
          case (in_op)
            OP_ENQ: begin
              if (!free_nil) begin
                // store item, hook behind tail, fetch next free link
                data_req.wr_en   = 1'b1;
                data_req.wr_addr = free_head[ADDR_W-1:0];
                data_req.wr_data = {in_price, in_id};
                link_req.rd_en   = 1'b1;
                link_req.rd_addr = free_head[ADDR_W-1:0];
                if (head_nil) begin
                  head_next        = free_head;
                  front_id_next    = in_id;
                  front_price_next = in_price;
                end else begin
                  link_req.wr_en   = 1'b1;
                  link_req.wr_addr = tail[ADDR_W-1:0];
                  link_req.wr_data = free_head;
                end
                tail_next    = free_head;
                fresh_q_next = (free_head >= fill);
                done_q_next  = 1'b1;
                state_next   = ST_LINK;
              end
            end
            OP_DEQ: begin
              if (!head_nil) begin
                done_q_next = 1'b1;
                if (head == tail) begin
                  // last item: queue empties, slot goes to free front
                  link_req.wr_en   = 1'b1;
                  link_req.wr_addr = head[ADDR_W-1:0];
                  link_req.wr_data = free_head;
                  free_head_next   = head;
                  head_next        = NIL_SLOT;
                  tail_next        = NIL_SLOT;
                end else begin
                  link_req.rd_en   = 1'b1;
                  link_req.rd_addr = head[ADDR_W-1:0];
                  state_next       = ST_LINK;
                end
              end
            end
            OP_QRY: begin
              done_q_next = 1'b1;
            end
            default: begin
              done_q_next = 1'b0;
            end
          endcase
        end
      end

      ST_LINK: begin
        if (op_q == OP_ENQ) begin
          // advance free list
          free_head_next = free_link;
          if (fresh_q) begin
            fill_next = fill + IDX_W'(1);
          end
          state_next = ST_DONE;
        end else begin
          // unlink head, recycle slot, fetch new front data
          link_req.wr_en   = 1'b1;
          link_req.wr_addr = head[ADDR_W-1:0];
          link_req.wr_data = free_head;
          free_head_next   = head;
          head_next        = link_rd_data;
          data_req.rd_en   = 1'b1;
          data_req.rd_addr = link_rd_data[ADDR_W-1:0];
          state_next       = ST_DATA;
        end
      end

      ST_DATA: begin
        front_id_next    = data_rd_data[ID_W-1:0];
        front_price_next = data_rd_data[DATA_W-1:ID_W];
        state_next       = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result view of the current state
  always_comb begin
    res.op_done     = done_q;
    res.is_full     = free_nil;
    res.is_empty    = head_nil;
    res.front_id    = head_nil ? EMPTY_ID : front_id;
    res.front_price = head_nil ? '0 : front_price;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= NIL_SLOT;
      tail      <= NIL_SLOT;
      free_head <= '0;
      fill      <= '0;
      op_q      <= OP_QRY;
      fresh_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      free_head <= free_head_next;
      fill      <= fill_next;
      op_q      <= op_q_next;
      fresh_q   <= fresh_q_next;
      done_q    <= done_q_next;
    end
  end

  // front item cache
  always_ff @(posedge clk) begin
    front_id    <= front_id_next;
    front_price <= front_price_next;
  end

endmodule

// ----- hw/rtl/linked_pool_fifo.sv -----
// linked_pool_fifo: top level with link ram, data ram, sequencer and
// output register; depends on lpf_pkg, lpf_ram and lpf_ctrl
//
// A fifo of (id, price) items kept as a linked list in a pool of
// POOL_DEPTH slots, with a second linked list of free slots.
// Input stream: s_tuser carries the opcode (enqueue, dequeue, query),
// s_tdata carries the item. Each request gives exactly one result on the
// output stream: front item after the request (id 9999, price 0 when the
// queue is empty), empty and full flags, and whether the request took
// effect. An enqueue into a full pool is dropped, a dequeue of an empty
// queue is ignored; both report op_done 0.
// Requests are handled one at a time. A query goes straight from
// acceptance to its result; an enqueue passes through a link step, and a
// dequeue through a link step and then a data step: the link ram read of
// the head, then the data ram read of the new head. A dequeue of the last
// item, a dropped enqueue or an ignored dequeue goes straight to its result.
// The result is loaded into the output register as the sequencer
// finishes; the next request is accepted while it waits there.
// If the receiver stalls, the result holds and the sequencer stops at its
// last step, so a second request waits for room in the output register.
// Reset empties the queue and frees every slot at once; no clearing pass.
module linked_pool_fifo
  import lpf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata: item_id [15:0], item_price [47:16]
  input  logic [DATA_W-1:0]      s_tdata,
  // s_tuser: opcode [1:0]
  input  logic [OP_W-1:0]        s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata: front_id [15:0], front_price [47:16], is_empty [48],
  // is_full [49], op_done [50], zero fill [55:51]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  link_req_t          link_req;
  data_req_t          data_req;
  logic [IDX_W-1:0]   link_rd_data;
  logic [DATA_W-1:0]  data_rd_data;
  logic               res_valid;
  logic               res_ready;
  result_t            res;

  // next-slot links
  lpf_ram #(
    .WIDTH(IDX_W),
    .DEPTH(POOL_DEPTH)
  ) u_link_ram (
    .clk    (clk),
    .wr_en  (link_req.wr_en),
    .wr_addr(link_req.wr_addr),
    .wr_data(link_req.wr_data),
    .rd_en  (link_req.rd_en),
    .rd_addr(link_req.rd_addr),
    .rd_data(link_rd_data)
  );

  // item payloads
  lpf_ram #(
    .WIDTH(DATA_W),
    .DEPTH(POOL_DEPTH)
  ) u_data_ram (
    .clk    (clk),
    .wr_en  (data_req.wr_en),
    .wr_addr(data_req.wr_addr),
    .wr_data(data_req.wr_data),
    .rd_en  (data_req.rd_en),
    .rd_addr(data_req.rd_addr),
    .rd_data(data_rd_data)
  );

  lpf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser),
    .in_id       (s_tdata[ID_W-1:0]),
    .in_price    (s_tdata[DATA_W-1:ID_W]),
    .link_req    (link_req),
    .link_rd_data(link_rd_data),
    .data_req    (data_req),
    .data_rd_data(data_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {{(OUT_TDATA_W - OUT_BITS){1'b0}}, res};
    end
  end

endmodule

// ----- hw/rtl/lpf_checker.sv -----
// lpf_checker: port-level assertions for linked_pool_fifo, bound to the
// top level; depends on lpf_pkg
module lpf_checker
  import lpf_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [DATA_W-1:0]      s_tdata,
  input logic [OP_W-1:0]        s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // empty queue reports the empty marker item
  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_EMPTY_BIT] |->
      m_tdata[ID_W-1:0] == EMPTY_ID && m_tdata[DATA_W-1:ID_W] == '0)
    else $error("empty result without marker item");

  // a full pool holds items, so the queue cannot be empty
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_FULL_BIT] |-> !m_tdata[OUT_EMPTY_BIT])
    else $error("full and empty at once");

  // one request at a time: no acceptance in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted back to back");

  // the zero fill of the result stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_BITS] == '0)
    else $error("result padding not zero");

endmodule

bind linked_pool_fifo lpf_checker u_lpf_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
